// ----- rtl/core/cstb_pkg.sv -----
// Shared types, constants and helper functions of the compare-scan-to-bitmap block.
package cstb_pkg;

    // Width of one column element as compared; bits above the 32-bit field read as zero.
    localparam int ELEMENT_BITS = 32;
    localparam int VALUE_W      = 32;
    localparam int WORD_BITS    = 64;
    localparam int POS_W        = $clog2(WORD_BITS);
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int S_TDATA_W    = VALUE_W + WORD_BITS;
    localparam int M_TDATA_W    = WORD_BITS;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(WORD_BITS - 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_COMPARE_OP      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMBINE_OP      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_VALUE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_COMPARE  = 2'd3;

    typedef enum logic [2:0] {
        CMP_GT = 3'd0,
        CMP_GE = 3'd1,
        CMP_LT = 3'd2,
        CMP_LE = 3'd3,
        CMP_EQ = 3'd4,
        CMP_NE = 3'd5
    } cmp_op_t;

    typedef enum logic [1:0] {
        COMB_SET    = 2'd0,
        COMB_AND    = 2'd1,
        COMB_OR     = 2'd2,
        COMB_ANDNOT = 2'd3
    } comb_op_t;

    typedef struct packed {
        logic             emit;
        logic [POS_W-1:0] bit_pos;
    } pack_status_t;

    // Reduces a raw value to the element width and flips the sign bit for a signed
    // compare, so that an unsigned compare of the keys gives the wanted order.
    function automatic logic [ELEMENT_BITS-1:0] order_key(input logic [VALUE_W-1:0] raw,
                                                           input logic              sgn);
        logic [63:0]             wide;
        logic [ELEMENT_BITS-1:0] key;
        wide = 64'(raw);
        key  = wide[ELEMENT_BITS-1:0];
        key[ELEMENT_BITS-1] = key[ELEMENT_BITS-1] ^ sgn;
        return key;
    endfunction

endpackage

// ----- rtl/core/cstb_compare.sv -----
// Predicate unit: compares one element against the reference value.
module cstb_compare (
    input  logic [cstb_pkg::VALUE_W-1:0] element_value,
    input  logic [cstb_pkg::VALUE_W-1:0] reference_value,
    input  logic                         signed_compare,
    input  cstb_pkg::cmp_op_t            compare_op,
    output logic                         match
);

    logic [cstb_pkg::ELEMENT_BITS-1:0] key_a;
    logic [cstb_pkg::ELEMENT_BITS-1:0] key_b;

    assign key_a = cstb_pkg::order_key(element_value, signed_compare);
    assign key_b = cstb_pkg::order_key(reference_value, signed_compare);

    always_comb begin
        case (compare_op)
            cstb_pkg::CMP_GT: match = (key_a > key_b);
            cstb_pkg::CMP_GE: match = (key_a >= key_b);
            cstb_pkg::CMP_LT: match = (key_a < key_b);
            cstb_pkg::CMP_LE: match = (key_a <= key_b);
            cstb_pkg::CMP_EQ: match = (key_a == key_b);
            cstb_pkg::CMP_NE: match = (key_a != key_b);
            // Unassigned operator codes never match.
            default:          match = 1'b0;
        endcase
    end

endmodule

// ----- rtl/core/cstb_pack.sv -----
// Bit packer: gathers match bits into a word and merges it with the prior word.
module cstb_pack (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           advance,
    input  logic                           match,
    input  logic                           last_element,
    input  logic [cstb_pkg::WORD_BITS-1:0] prior_word,
    input  cstb_pkg::comb_op_t             combine_op,
    output logic [cstb_pkg::WORD_BITS-1:0] merged_word,
    output cstb_pkg::pack_status_t         status
);

    logic [cstb_pkg::WORD_BITS-1:0] partial_word_reg;
    logic [cstb_pkg::WORD_BITS-1:0] partial_word_next;
    logic [cstb_pkg::POS_W-1:0]     bit_pos_reg;
    logic [cstb_pkg::POS_W-1:0]     bit_pos_next;
    logic [cstb_pkg::WORD_BITS-1:0] filled_word;
    logic                           emit;

    assign filled_word = partial_word_reg
                       | (cstb_pkg::WORD_BITS'(match) << bit_pos_reg);
    assign emit        = (bit_pos_reg == cstb_pkg::LAST_POS) || last_element;

    always_comb begin
        case (combine_op)
            cstb_pkg::COMB_SET:    merged_word = filled_word;
            cstb_pkg::COMB_AND:    merged_word = prior_word & filled_word;
            cstb_pkg::COMB_OR:     merged_word = prior_word | filled_word;
            cstb_pkg::COMB_ANDNOT: merged_word = prior_word & ~filled_word;
            default:               merged_word = filled_word;
        endcase
    end

    always_comb begin
        partial_word_next = partial_word_reg;
        bit_pos_next      = bit_pos_reg;
        if (advance) begin
            if (emit) begin
                partial_word_next = '0;
                bit_pos_next      = '0;
            end else begin
                partial_word_next = filled_word;
                bit_pos_next      = bit_pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_word_reg <= '0;
            bit_pos_reg      <= '0;
        end else begin
            partial_word_reg <= partial_word_next;
            bit_pos_reg      <= bit_pos_next;
        end
    end

    assign status.emit    = emit;
    assign status.bit_pos = bit_pos_reg;

endmodule

// ----- rtl/core/compare_scan_to_bitmap_top.sv -----
// Top level of the compare-scan-to-bitmap block: registers, handshakes and checks.
//
// Use: column elements arrive on the s_ stream, one per transaction, each with the
// prior match-vector word of its 64-element group and tlast on the final element of
// the column. Each element is compared against the configured reference value; the
// match bits are packed least significant bit first. On the 64th element of a group,
// or on the last element, the word is merged with the prior word carried by that
// transaction and sent as one m_ transaction, with m_tlast set when it closes the
// column. Other elements produce no output transaction.
// The accepting edge loads the input register; when the element closes a word, the
// merged word then goes into the output register, which drives m_tvalid. Throughput:
// one element per cycle when not stalled, set by the single compare and bit insert
// between the two registers. Stalls: when m_tready is low the output register holds
// its word; the input register keeps taking elements that do not close a word, and
// s_tready drops only when a closing element is waiting behind a full output
// register. Reset (aresetn low, synchronous) empties both registers, clears the
// partial word and bit position, and returns all configuration registers to zero.
// The user must write configuration through cfg_we/cfg_index/cfg_data only while the
// block is idle; the block itself does not enforce this.
module compare_scan_to_bitmap_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port.
    input  logic                            cfg_we,
    input  logic [cstb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cstb_pkg::CFG_DATA_W-1:0] cfg_data,
    // Element stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata fields from bit 0: element_value [31:0], prior_word [95:32].
    input  logic [cstb_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tlast,      // last_element
    // Match word stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata fields from bit 0: merged_word [63:0].
    output logic [cstb_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tlast       // final_word
);

    // Configuration registers.
    cstb_pkg::cmp_op_t              compare_op_reg;
    cstb_pkg::comb_op_t             combine_op_reg;
    logic [cstb_pkg::VALUE_W-1:0]   reference_value_reg;
    logic                           signed_compare_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            compare_op_reg      <= cstb_pkg::CMP_GT;
            combine_op_reg      <= cstb_pkg::COMB_SET;
            reference_value_reg <= '0;
            signed_compare_reg  <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                cstb_pkg::REG_COMPARE_OP:
                    compare_op_reg <= cstb_pkg::cmp_op_t'(cfg_data[2:0]);
                cstb_pkg::REG_COMBINE_OP:
                    combine_op_reg <= cstb_pkg::comb_op_t'(cfg_data[1:0]);
                cstb_pkg::REG_REFERENCE_VALUE:
                    reference_value_reg <= cfg_data[cstb_pkg::VALUE_W-1:0];
                cstb_pkg::REG_SIGNED_COMPARE:
                    signed_compare_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input register: holds one accepted element until the packer takes it.
    logic                           in_valid_reg;
    logic [cstb_pkg::VALUE_W-1:0]   in_elem_reg;
    logic [cstb_pkg::WORD_BITS-1:0] in_prior_reg;
    logic                           in_last_reg;

    // Output register.
    logic                           out_valid_reg;
    logic [cstb_pkg::WORD_BITS-1:0] out_word_reg;
    logic                           out_last_reg;

    logic                           match;
    logic [cstb_pkg::WORD_BITS-1:0] merged_word;
    cstb_pkg::pack_status_t         pack_status;
    logic                           out_free;
    logic                           in_advance;
    logic                           s_accept;

    // A held element moves on unless it closes a word and the output is still full.
    assign out_free   = !out_valid_reg || m_tready;
    assign in_advance = in_valid_reg && (!pack_status.emit || out_free);
    assign s_tready   = !in_valid_reg || in_advance;
    assign s_accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (in_advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_elem_reg  <= s_tdata[cstb_pkg::VALUE_W-1:0];
            in_prior_reg <= s_tdata[cstb_pkg::S_TDATA_W-1:cstb_pkg::VALUE_W];
            in_last_reg  <= s_tlast;
        end
    end

    cstb_compare u_compare (
        .element_value   (in_elem_reg),
        .reference_value (reference_value_reg),
        .signed_compare  (signed_compare_reg),
        .compare_op      (compare_op_reg),
        .match           (match)
    );

    cstb_pack u_pack (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (in_advance),
        .match        (match),
        .last_element (in_last_reg),
        .prior_word   (in_prior_reg),
        .combine_op   (combine_op_reg),
        .merged_word  (merged_word),
        .status       (pack_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_advance && pack_status.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_advance && pack_status.emit) begin
            out_word_reg <= merged_word;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // An element waiting in the input register is never dropped.
    a_in_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !in_advance |=> in_valid_reg)
        else $error("input element lost while stalled");

    // The last element of a column always restarts the bit position.
    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_advance && in_last_reg |=> pack_status.bit_pos == '0)
        else $error("bit position not cleared after last element");

    // A new output word only ever comes from an element that closes a word.
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_advance && pack_status.emit))
        else $error("output word without a closing element");
`endif

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench of the compare-scan-to-bitmap block.
`timescale 1ns / 100ps

module testbench;
    import cstb_pkg::*;

    // Random stimulus stops once this many elements have been queued.
    localparam int TOTAL_ELEMENTS = 1450;
    // Settling time after the last word: two register stages plus some margin.
    localparam int DRAIN_CYCLES   = 6;

    typedef struct {
        logic [VALUE_W-1:0]   value;
        logic [WORD_BITS-1:0] prior;
        logic                 last;
    } element_t;

    typedef struct {
        logic [WORD_BITS-1:0] word;
        logic                 last;
    } match_word_t;

    // Values on which the signed and unsigned orders disagree or saturate.
    localparam logic [31:0] CORNER_VALUES [4] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                                 32'h8000_0000, 32'h7FFF_FFFF};

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;

    compare_scan_to_bitmap_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // The testbench's own copy of the configuration, kept in step with every write.
    logic [2:0]             cur_cmp    = CMP_GT;
    comb_op_t               cur_comb   = COMB_SET;
    logic [31:0]            cur_ref    = '0;
    logic                   cur_signed = 1'b0;

    // Match bits gathered for the group in progress and the next bit to fill.
    logic [WORD_BITS-1:0]   acc_word = '0;
    logic [POS_W-1:0]       acc_pos  = '0;

    element_t               pending_elements [$];
    match_word_t            expected_words   [$];

    element_t               in_flight;
    match_word_t            oldest;
    int                     errors     = 0;
    int                     send_gap   = 0;
    int                     hold_left  = 0;
    bit                     send_burst = 1'b0;
    bit                     recv_burst = 1'b0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Watchdog: far beyond the slowest correct run, in which every element waits out
    // the longest gap and every word the longest stall.
    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Flipping the sign bit turns a two's complement compare into an unsigned one.
    function automatic logic element_matches(input logic [31:0] value);
        logic [31:0] a;
        logic [31:0] b;
        a = value   ^ {cur_signed, 31'd0};
        b = cur_ref ^ {cur_signed, 31'd0};
        case (cur_cmp)
            CMP_GT:  return a >  b;
            CMP_GE:  return a >= b;
            CMP_LT:  return a <  b;
            CMP_LE:  return a <= b;
            CMP_EQ:  return a == b;
            CMP_NE:  return a != b;
            default: return 1'b0;
        endcase
    endfunction

    // Folds one accepted element into the group; a full group or the last element of
    // the column closes the word, which is merged with that element's prior word.
    function automatic void scan_element(input element_t e);
        match_word_t r;
        if (element_matches(e.value)) begin
            acc_word[acc_pos] = 1'b1;
        end
        if (acc_pos != LAST_POS && !e.last) begin
            acc_pos = acc_pos + 1'b1;
        end else begin
            case (cur_comb)
                COMB_SET: r.word = acc_word;
                COMB_AND: r.word = e.prior & acc_word;
                COMB_OR:  r.word = e.prior | acc_word;
                default:  r.word = e.prior & ~acc_word;
            endcase
            r.last = e.last;
            expected_words.push_back(r);
            acc_word = '0;
            acc_pos  = '0;
        end
    endfunction

    // Mostly back-to-back, often a short gap, now and then a long one.
    function automatic int pick_gap(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 65) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(8, 40);
        end
    endfunction

    // Element values cluster around the reference so that every operator flips often.
    function automatic logic [31:0] pick_element();
        case ($urandom_range(0, 5))
            0:       return cur_ref;
            1:       return cur_ref + 32'd1;
            2:       return cur_ref - 32'd1;
            3:       return CORNER_VALUES[$urandom_range(0, 3)];
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [63:0] pick_prior();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Column lengths: whole words, one past or short of a word, single elements,
    // and plenty of arbitrary lengths in between.
    function automatic int pick_column_length();
        case ($urandom_range(0, 9))
            0:       return 64;
            1:       return 128;
            2:       return 1;
            3:       return $urandom_range(0, 1) ? 63 : 65;
            default: return $urandom_range(2, 100);
        endcase
    endfunction

    function automatic void queue_element(input logic [31:0] value, input logic [63:0] prior,
                                          input logic last);
        element_t e;
        e.value = value;
        e.prior = prior;
        e.last  = last;
        pending_elements.push_back(e);
    endfunction

    // One register write, taken at the rising edge at which cfg_we is high.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_COMPARE_OP:      cur_cmp    = data[2:0];
            REG_COMBINE_OP:      cur_comb   = comb_op_t'(data[1:0]);
            REG_REFERENCE_VALUE: cur_ref    = data;
            default:             cur_signed = data[0];
        endcase
    endtask

    // Writes all four registers. With noisy set, the unused upper bits of the narrow
    // registers carry random values, which the block must ignore.
    task automatic apply_setting(input logic [2:0] cmp, input logic [1:0] comb,
                                 input logic [31:0] refv, input logic sgn, input bit noisy);
        logic [31:0] upper;
        upper = noisy ? $urandom() : 32'd0;
        write_reg(REG_COMPARE_OP,      (upper & ~32'h7) | 32'(cmp));
        write_reg(REG_COMBINE_OP,      (upper & ~32'h3) | 32'(comb));
        write_reg(REG_REFERENCE_VALUE, refv);
        write_reg(REG_SIGNED_COMPARE,  (upper & ~32'h1) | 32'(sgn));
    endtask

    // The sender holds off until every queued element has gone and every expected word
    // has arrived, then lets the pipeline settle so that an element which closed no
    // word has been folded in before anything else happens.
    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (pending_elements.size() != 0 || s_tvalid || expected_words.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Driver: presents queued elements on the s_ side. A transaction is folded into the
    // prediction at the edge that accepts it; while idle, tdata and tlast carry noise.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap  = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                scan_element(in_flight);
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap == 0 && pending_elements.size() != 0) begin
                    in_flight = pending_elements.pop_front();
                    s_tdata  <= {in_flight.prior, in_flight.value};
                    s_tlast  <= in_flight.last;
                    s_tvalid <= 1'b1;
                    send_gap  = pick_gap(send_burst);
                end else begin
                    if (send_gap > 0) begin
                        send_gap = send_gap - 1;
                    end
                    s_tdata  <= {$urandom(), $urandom(), $urandom()};
                    s_tlast  <= 1'($urandom_range(0, 1));
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: every word accepted on the m_ side must match the oldest expectation,
    // field by field. m_tready is withdrawn at random to exercise back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected match word: expected none, got %h last %b",
                             $time, m_tdata, m_tlast);
                    errors++;
                end else begin
                    oldest = expected_words.pop_front();
                    if (m_tdata !== oldest.word) begin
                        $display("%0t: merged word mismatch: expected %h, got %h",
                                 $time, oldest.word, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== oldest.last) begin
                        $display("%0t: final word flag mismatch: expected %b, got %b",
                                 $time, oldest.last, m_tlast);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                hold_left = pick_gap(recv_burst);
            end
        end
    end

    // Stimulus sequence: directed checks first, then random phases, each phase under a
    // fresh configuration written while the block is idle.
    initial begin
        int          queued;
        int          budget;
        int          phase_items;
        int          col_len;
        logic [31:0] refv;

        queued = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset configuration (unsigned greater-than zero, plain set): a short column.
        @(negedge aclk);
        queue_element(32'h0000_0001, pick_prior(), 1'b0);
        queue_element(32'h0000_0000, '1, 1'b1);
        queued += 2;
        wait_idle();

        // Every compare code, including the two unused ones, each against a corner
        // reference, cycling through the merge operators and both signednesses. Each
        // short column tests equality with the reference, the opposite corner and a
        // value just above the reference.
        for (int code = 0; code < 8; code++) begin
            refv = CORNER_VALUES[code % 4];
            apply_setting(3'(code), 2'(code % 4), refv, code[1] ^ code[0], 1'b0);
            @(negedge aclk);
            queue_element(refv, pick_prior(), 1'b0);
            queue_element(~refv, pick_prior(), 1'b0);
            queue_element(refv + 32'd1, CORNER_VALUES[code % 2] == 0 ? '0 : '1, 1'b1);
            queued += 3;
            wait_idle();
        end

        // Random phases. Most traffic is well-formed columns; some phases end part way
        // through a column, so its group carries over into the next setting.
        while (queued < TOTAL_ELEMENTS) begin
            case ($urandom_range(0, 4))
                0:       refv = CORNER_VALUES[$urandom_range(0, 3)];
                1:       refv = $urandom_range(0, 15);
                default: refv = $urandom();
            endcase
            apply_setting(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), refv,
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            send_burst = ($urandom_range(0, 3) == 0);
            recv_burst = ($urandom_range(0, 3) == 0);
            budget      = $urandom_range(100, 220);
            phase_items = 0;
            @(negedge aclk);
            while (phase_items < budget) begin
                col_len = pick_column_length();
                for (int i = 0; i < col_len; i++) begin
                    queue_element(pick_element(), pick_prior(), i == col_len - 1);
                end
                phase_items += col_len;
            end
            if ($urandom_range(0, 9) < 3) begin
                col_len = $urandom_range(1, 40);
                for (int i = 0; i < col_len; i++) begin
                    queue_element(pick_element(), pick_prior(), 1'b0);
                end
                phase_items += col_len;
            end
            queued += phase_items;
            wait_idle();
        end

        // Close any group left open so that nothing remains inside the block.
        @(negedge aclk);
        queue_element(pick_element(), pick_prior(), 1'b1);
        wait_idle();

        if (errors == 0 && expected_words.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- compare_scan_to_bitmap_top.f -----
rtl/core/cstb_pkg.sv
rtl/core/cstb_compare.sv
rtl/core/cstb_pack.sv
rtl/core/compare_scan_to_bitmap_top.sv
test/testbench.sv
